// File: rtl/request_dedup_window_table_defines.svh
// Assertion macros shared by the checker files.
`ifndef REQUEST_DEDUP_WINDOW_TABLE_DEFINES_SVH
`define REQUEST_DEDUP_WINDOW_TABLE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RDWT_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rdwt check failed");

// antecedent implies consequent in the next cycle
`define RDWT_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rdwt check failed");

// consequent holds in the cycle after reset
`define RDWT_ASSERT_RST(lbl, clk, rst, c) \
  lbl: assert property (@(posedge clk) (rst) |=> (c)) \
    else $error("rdwt reset check failed");

`endif

// File: rtl/rdwt_pkg.sv
// ---------------------------------------------------------------------------
// rdwt_pkg
// Types and codes shared by the request dedup window table modules.
// ---------------------------------------------------------------------------
package rdwt_pkg;

  localparam logic [1:0] STATUS_NONE      = 2'd0;
  localparam logic [1:0] STATUS_PENDING   = 2'd1;
  localparam logic [1:0] STATUS_COMMITTED = 2'd2;

  localparam logic [1:0] OP_CHECK  = 2'd0;
  localparam logic [1:0] OP_TRACK  = 2'd1;
  localparam logic [1:0] OP_RECORD = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_CHECK,
    KIND_TRACK,
    KIND_RECORD
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] key;
    logic [63:0] pos;
    logic        ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] pos;
    logic        ok;
    logic        ovf;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_POP_CHECK,
    ST_INSERT,
    ST_PUSH,
    ST_EVICT,
    ST_DONE
  } state_t;

endpackage

// File: rtl/rdwt_ram.sv
// ---------------------------------------------------------------------------
// rdwt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rdwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rdwt_front.sv
// ---------------------------------------------------------------------------
// rdwt_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module rdwt_front import rdwt_pkg::*; #(
  parameter int KEY_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic        key_present,
  input  logic [63:0] request_key,
  input  logic [63:0] log_position,
  input  logic        outcome_ok,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  localparam logic [63:0] KEY_MASK = 64'(~(64'd0)) >> (64 - KEY_BITS);

  cmd_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  cmd_t       in_cmd;
  logic       accept;

  assign busy      = (count == 2'd2);
  assign accept    = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rptr];

  always_comb begin
    in_cmd.key = request_key & KEY_MASK;
    in_cmd.pos = log_position;
    in_cmd.ok  = outcome_ok;
    if (!key_present) begin
      in_cmd.kind = KIND_NOP;
    end else begin
      unique case (opcode)
        OP_CHECK:  in_cmd.kind = KIND_CHECK;
        OP_TRACK:  in_cmd.kind = KIND_TRACK;
        OP_RECORD: in_cmd.kind = KIND_RECORD;
        default:   in_cmd.kind = KIND_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) begin
        wptr <= ~wptr;
      end
      if (cmd_take) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, accept} - {1'b0, cmd_take};
    end
  end

endmodule

// File: rtl/rdwt_back.sv
// ---------------------------------------------------------------------------
// rdwt_back
// Executes requests against the entry table and the order queue.
// ---------------------------------------------------------------------------
module rdwt_back import rdwt_pkg::*; #(
  parameter int TABLE_CAPACITY = 64,
  parameter int QUEUE_DEPTH    = 128,
  parameter int KEY_BITS       = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  output logic       done,
  output res_t       res
);

  localparam int IW  = $clog2(TABLE_CAPACITY);
  localparam int LW  = $clog2(TABLE_CAPACITY + 1);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW  = QW + 1;
  localparam int EW  = KEY_BITS + 66;
  localparam int QDW = KEY_BITS + 64;

  state_t state, state_next;

  logic [6:0]                window_limit;
  logic [TABLE_CAPACITY-1:0] entry_valid;
  logic [LW-1:0]             live_count;
  logic [QW-1:0]             queue_head;
  logic [QCW-1:0]            queue_count;

  cmd_t                cur;
  logic [KEY_BITS-1:0] scan_key;
  logic [63:0]         pop_pos;
  logic                scan_pop;
  logic                pop_win;
  logic [LW-1:0]       scan_cnt;
  logic                cmp_vld;
  logic [IW-1:0]       cmp_idx;
  logic                hit_found;
  logic [IW-1:0]       hit_idx;
  logic [63:0]         hit_pos;
  logic                hit_comm;
  logic                hit_ok;
  logic                free_found;
  logic [IW-1:0]       free_idx;
  logic [IW-1:0]       tgt;
  logic                ins_new;

  // memories
  logic           ent_we;
  logic [IW-1:0]  ent_waddr;
  logic [IW-1:0]  ent_raddr;
  logic [EW-1:0]  ent_wdata;
  logic [EW-1:0]  ent_rdata;
  logic           q_we;
  logic [QW-1:0]  q_waddr;
  logic [QDW-1:0] q_wdata;
  logic [QDW-1:0] q_rdata;

  logic                scan_issue;
  logic                scan_match;
  logic                scan_last;
  logic                pop_evicted;
  logic                table_full;
  logic                queue_empty;
  logic                over_window;
  logic [TW-1:0]       tail_sum;
  logic [TW-1:0]       tail_wrap;
  logic [QW-1:0]       queue_tail;
  logic [QW-1:0]       head_inc;

  rdwt_ram #(.WIDTH(EW), .DEPTH(TABLE_CAPACITY)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  rdwt_ram #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (queue_head),
    .rdata (q_rdata)
  );

  assign scan_issue  = (scan_cnt < LW'(TABLE_CAPACITY));
  assign scan_match  = cmp_vld && entry_valid[cmp_idx] &&
                       (ent_rdata[EW-1:66] == scan_key);
  assign scan_last   = cmp_vld && (cmp_idx == IW'(TABLE_CAPACITY - 1));
  assign pop_evicted = hit_found && (hit_pos == pop_pos);
  assign table_full  = (live_count >= LW'(TABLE_CAPACITY));
  assign queue_empty = (queue_count == '0);
  // live > min(limit, capacity) reduces to live > limit since live <= capacity
  assign over_window = ({{7{1'b0}}, live_count} > {{LW{1'b0}}, window_limit});
  assign tail_sum    = TW'(queue_head) + TW'(queue_count);
  assign tail_wrap   = (tail_sum >= TW'(QUEUE_DEPTH)) ? tail_sum - TW'(QUEUE_DEPTH)
                                                      : tail_sum;
  assign queue_tail  = tail_wrap[QW-1:0];
  assign head_inc    = (queue_head == QW'(QUEUE_DEPTH - 1)) ? '0 : queue_head + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.kind == KIND_NOP) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_match || scan_last) begin
          state_next = scan_pop ? ST_POP_CHECK : ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit_found) begin
          state_next = (cur.kind == KIND_RECORD) ? ST_INSERT : ST_DONE;
        end else if (cur.kind == KIND_CHECK) begin
          state_next = ST_DONE;
        end else if (!table_full) begin
          state_next = ST_INSERT;
        end else if (!queue_empty) begin
          state_next = ST_POP_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_POP_RD:   state_next = ST_POP_WAIT;
      ST_POP_WAIT: state_next = ST_SCAN;
      ST_POP_CHECK: begin
        if (pop_win) begin
          state_next = ST_EVICT;
        end else if (pop_evicted) begin
          state_next = ST_INSERT;
        end else if (!queue_empty) begin
          state_next = ST_POP_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_INSERT: state_next = ST_PUSH;
      ST_PUSH:   state_next = ST_EVICT;
      ST_EVICT:  state_next = (over_window && !queue_empty) ? ST_POP_RD : ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_take  = 1'b0;
    done      = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = tgt;
    ent_raddr = scan_cnt[IW-1:0];
    ent_wdata = {scan_key, cur.pos, (cur.kind == KIND_RECORD),
                 (cur.kind == KIND_RECORD) && cur.ok};
    q_we      = 1'b0;
    q_waddr   = queue_tail;
    q_wdata   = {scan_key, cur.pos};
    unique case (state)
      ST_IDLE:   cmd_take = cmd_valid;
      ST_INSERT: ent_we   = 1'b1;
      ST_PUSH:   q_we     = (queue_count < QCW'(QUEUE_DEPTH));
      ST_DONE:   done     = 1'b1;
      default: begin
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    cmp_vld <= (state == ST_SCAN) && scan_issue;
    cmp_idx <= scan_cnt[IW-1:0];
    unique case (state)
      ST_IDLE: begin
        cur        <= cmd;
        scan_key   <= cmd.key[KEY_BITS-1:0];
        scan_pop   <= 1'b0;
        pop_win    <= 1'b0;
        scan_cnt   <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        res        <= '0;
      end
      ST_SCAN: begin
        if (scan_issue) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
        if (scan_match) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
          hit_pos   <= ent_rdata[65:2];
          hit_comm  <= ent_rdata[1];
          hit_ok    <= ent_rdata[0];
        end
        if (cmp_vld && !entry_valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
      ST_DECIDE: begin
        tgt     <= hit_found ? hit_idx : free_idx;
        ins_new <= !hit_found;
        if (hit_found && cur.kind != KIND_RECORD) begin
          res.status <= hit_comm ? STATUS_COMMITTED : STATUS_PENDING;
          res.pos    <= hit_pos;
          res.ok     <= hit_ok;
        end
        if (!hit_found && cur.kind == KIND_TRACK) begin
          res.pos <= cur.pos;
        end
        if (!hit_found && cur.kind != KIND_CHECK && table_full && queue_empty) begin
          res.ovf <= 1'b1;
        end
      end
      ST_POP_WAIT: begin
        scan_key  <= q_rdata[QDW-1:64];
        pop_pos   <= q_rdata[63:0];
        scan_pop  <= 1'b1;
        scan_cnt  <= '0;
        hit_found <= 1'b0;
      end
      ST_POP_CHECK: begin
        // restore the request key for the insert and push that follow
        scan_key <= cur.key[KEY_BITS-1:0];
        scan_pop <= 1'b0;
        if (!pop_win) begin
          tgt     <= hit_idx;
          ins_new <= 1'b1;
          if (!pop_evicted && queue_empty) begin
            res.ovf <= 1'b1;
          end
        end
      end
      ST_PUSH: begin
        pop_win <= 1'b1;
        if (queue_count >= QCW'(QUEUE_DEPTH)) begin
          res.ovf <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_limit <= 7'd64;
      entry_valid  <= '0;
      live_count   <= '0;
      queue_head   <= '0;
      queue_count  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        window_limit <= cfg_data;
      end
      if (state == ST_POP_RD) begin
        queue_head  <= head_inc;
        queue_count <= queue_count - 1'b1;
      end
      if (state == ST_POP_CHECK && pop_evicted) begin
        entry_valid[hit_idx] <= 1'b0;
        live_count           <= live_count - 1'b1;
      end
      if (state == ST_INSERT && ins_new) begin
        entry_valid[tgt] <= 1'b1;
        live_count       <= live_count + 1'b1;
      end
      if (q_we) begin
        queue_count <= queue_count + 1'b1;
      end
    end
  end

endmodule

// File: rtl/request_dedup_window_table.sv
// ---------------------------------------------------------------------------
// request_dedup_window_table
// Request dedup table with pending/committed entries and FIFO-order eviction.
// ---------------------------------------------------------------------------
// channel   direction  handshake        payload
// request   in         start & !busy    opcode key_present request_key
//                                       log_position outcome_ok
// result    out        done (1 cycle)   status entry_log_position entry_ok
//                                       queue_overflow
// config    in         cfg_we           cfg_data (window_limit)
//
// Lookups scan the entry RAM one address a cycle until a key match or the
// last entry. A record, or a track that misses, then inserts the entry and
// pushes an order-queue record, and each order-queue record popped for
// eviction adds another scan. Empty-identifier or unused-opcode requests skip
// the scan. A two-entry queue holds requests while the back end works; busy
// is high when it is full.
// Reset is synchronous; results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
module request_dedup_window_table import rdwt_pkg::*; #(
  parameter int TABLE_CAPACITY = 64,
  parameter int QUEUE_DEPTH    = 128,
  parameter int KEY_BITS       = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic        key_present,
  input  logic [63:0] request_key,
  input  logic [63:0] log_position,
  input  logic        outcome_ok,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] entry_log_position,
  output logic        entry_ok,
  output logic        queue_overflow,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res;

  rdwt_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .key_present  (key_present),
    .request_key  (request_key),
    .log_position (log_position),
    .outcome_ok   (outcome_ok),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  rdwt_back #(
    .TABLE_CAPACITY (TABLE_CAPACITY),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .KEY_BITS       (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .done      (done),
    .res       (res)
  );

  assign status             = res.status;
  assign entry_log_position = res.pos;
  assign entry_ok           = res.ok;
  assign queue_overflow     = res.ovf;

endmodule

// File: rtl/rdwt_checker.sv
// ---------------------------------------------------------------------------
// rdwt_checker
// Port-level assertions for the request dedup window table.
// ---------------------------------------------------------------------------
`include "request_dedup_window_table_defines.svh"

module rdwt_checker import rdwt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        entry_ok
);

  `RDWT_ASSERT_RST(a_reset_idle, clk, rst, !busy && !done)
  `RDWT_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  `RDWT_ASSERT_IMP(a_status_code, clk, rst, done, status <= STATUS_COMMITTED)
  // pending entries never carry a success flag
  `RDWT_ASSERT_IMP(a_pending_not_ok, clk, rst, done && status == STATUS_PENDING, !entry_ok)

endmodule

bind request_dedup_window_table rdwt_checker u_rdwt_checker (.*);

// File: sim/tb_request_dedup_window_table.sv
// ---------------------------------------------------------------------------
// tb_request_dedup_window_table
// Drives requests into the dedup window table in bursts, predicts each result
// with a behavioral copy of the table and order queue, and compares fields.
// ---------------------------------------------------------------------------
module tb_request_dedup_window_table;
  import rdwt_pkg::*;

  localparam int CAP = 64;
  localparam int QD = 128;
  localparam int N_RANDOM = 800;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  typedef struct {
    logic [1:0]  op;
    logic        pres;
    logic [63:0] key;
    logic [63:0] pos;
    logic        ok;
    logic        has_exp;
    logic [1:0]  e_status;
    logic [63:0] e_pos;
    logic        e_ok;
    logic        e_ovf;
  } row_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] pos;
    logic        ok;
    logic        ovf;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = '0;
  logic key_present = 1'b0;
  logic [63:0] request_key = '0;
  logic [63:0] log_position = '0;
  logic outcome_ok = 1'b0;
  logic done;
  logic [1:0] status;
  logic [63:0] entry_log_position;
  logic entry_ok;
  logic queue_overflow;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  // predictor state
  logic [6:0]  win_limit;
  logic        tv [CAP];
  logic [63:0] tk [CAP];
  logic        tc [CAP];
  logic        ts [CAP];
  logic [63:0] tp [CAP];
  logic [63:0] qk [QD];
  logic [63:0] qp [QD];
  int q_head, q_count, live;

  answer_t pending_answers[$];
  int errors = 0;
  longint cycles = 0;
  logic [63:0] key_pool [16];

  request_dedup_window_table DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    answer_t a;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report("unexpected result", 64'(status), 64'd0);
      end else begin
        a = pending_answers[0];
        pending_answers.delete(0);
        if (status !== a.status) report("status", 64'(status), 64'(a.status));
        if (entry_log_position !== a.pos) report("pos", entry_log_position, a.pos);
        if (entry_ok !== a.ok) report("ok", 64'(entry_ok), 64'(a.ok));
        if (queue_overflow !== a.ovf) report("ovf", 64'(queue_overflow), 64'(a.ovf));
      end
    end
  end

  function automatic int lookup(input logic [63:0] k);
    for (int i = 0; i < CAP; i++) if (tv[i] && tk[i] == k) return i;
    return -1;
  endfunction

  function automatic logic pop_oldest();
    logic [63:0] k, p;
    int s;
    k = qk[q_head];
    p = qp[q_head];
    q_head = (q_head + 1) % QD;
    q_count--;
    s = lookup(k);
    if (s < 0 || tp[s] != p) return 1'b0;
    tv[s] = 1'b0;
    live--;
    return 1'b1;
  endfunction

  function automatic logic upsert(input logic [63:0] k, input logic [63:0] p,
                                  input logic c, input logic ok);
    int s, lim;
    logic lost;
    lim = (win_limit < CAP) ? win_limit : CAP;
    lost = 1'b0;
    s = lookup(k);
    if (s < 0) begin
      if (live >= CAP) begin
        while (q_count > 0 && !pop_oldest()) ;
      end
      for (int i = CAP - 1; i >= 0; i--) if (!tv[i]) s = i;
      if (s < 0) return 1'b1;
      tv[s] = 1'b1;
      tk[s] = k;
      live++;
    end
    tc[s] = c;
    ts[s] = ok;
    tp[s] = p;
    if (q_count < QD) begin
      qk[(q_head + q_count) % QD] = k;
      qp[(q_head + q_count) % QD] = p;
      q_count++;
    end else lost = 1'b1;
    while (live > lim && q_count > 0) void'(pop_oldest());
    return lost;
  endfunction

  function automatic answer_t predict_answer(input logic [1:0] op, input logic pres,
      input logic [63:0] k, input logic [63:0] p, input logic ok);
    answer_t a;
    int s;
    a = '{STATUS_NONE, 64'd0, 1'b0, 1'b0};
    if (pres && (op == OP_CHECK || op == OP_TRACK)) begin
      s = lookup(k);
      if (s >= 0) begin
        a.status = tc[s] ? STATUS_COMMITTED : STATUS_PENDING;
        a.pos = tp[s];
        a.ok = ts[s];
      end else if (op == OP_TRACK) begin
        a.ovf = upsert(k, p, 1'b0, 1'b0);
        a.pos = p;
      end
    end else if (pres && op == OP_RECORD) begin
      a.ovf = upsert(k, p, 1'b1, ok);
    end
    return a;
  endfunction

  // start stays high after a request; callers drop it before a gap
  task automatic send(input row_t r);
    answer_t a;
    start <= 1'b1;
    opcode <= r.op;
    key_present <= r.pres;
    request_key <= r.key;
    log_position <= r.pos;
    outcome_ok <= r.ok;
    do @(posedge clk); while (busy);
    a = predict_answer(r.op, r.pres, r.key, r.pos, r.ok);
    if (r.has_exp) begin
      if (a.status != r.e_status || a.pos != r.e_pos || a.ok != r.e_ok || a.ovf != r.e_ovf)
        report("table row", 64'({a.status, a.ok, a.ovf}), 64'({r.e_status, r.e_ok, r.e_ovf}));
      a = '{r.e_status, r.e_pos, r.e_ok, r.e_ovf};
    end
    pending_answers.push_back(a);
  endtask

  // wait out in-flight work; a full pop chain may be long
  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_window(input logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_limit = v;
  endtask

  function automatic row_t rand_row(input int mode);
    row_t r;
    r.op = (mode == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 2));
    r.pres = ($urandom_range(0, 19) != 0);
    r.key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 15)]
                                        : {$urandom, $urandom};
    r.pos = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 7))
                                        : {$urandom, $urandom};
    r.ok = 1'($urandom_range(0, 1));
    r.has_exp = 1'b0;
    return r;
  endfunction

  row_t directed [] = '{
    // after reset: empty table
    '{OP_CHECK,  1, 64'h0, 64'h5, 0, 1, STATUS_NONE, 64'h0, 0, 0},
    '{OP_TRACK,  1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1,
      STATUS_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0},
    '{OP_CHECK,  1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0, 1,
      STATUS_PENDING, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0},
    '{OP_RECORD, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7, 1, 1, STATUS_NONE, 64'h0, 0, 0},
    '{OP_TRACK,  1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h9, 0, 1, STATUS_COMMITTED, 64'h7, 1, 0},
    // empty identifier and unused opcode
    '{OP_RECORD, 0, 64'h1234, 64'h1, 1, 1, STATUS_NONE, 64'h0, 0, 0},
    '{OP_UNUSED, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1, 1, STATUS_NONE, 64'h0, 0, 0},
    '{OP_RECORD, 1, 64'h0, 64'h0, 0, 1, STATUS_NONE, 64'h0, 0, 0},
    '{OP_CHECK,  1, 64'h0, 64'h0, 0, 0, 0, 0, 0, 0},
    '{OP_TRACK,  1, 64'hA5A5_5A5A_0F0F_F0F0, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0, 0}
  };

  initial begin
    int n;
    row_t r;
    win_limit = 7'd64;
    q_head = 0;
    q_count = 0;
    live = 0;
    for (int i = 0; i < CAP; i++) tv[i] = 1'b0;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send(directed[i]);

    // window 0: every insert is evicted at once
    set_window(7'd0);
    for (int i = 0; i < 6; i++) send(rand_row(1));
    // above capacity: table fills, table-full path
    set_window(7'd127);
    for (int i = 0; i < 140; i++) begin
      r = rand_row(1);
      r.pres = 1'b1;
      r.op = OP_RECORD;
      r.key = {$urandom, $urandom};
      send(r);
    end

    n = 0;
    while (n < N_RANDOM) begin
      if (n % 200 == 100) begin
        case ($urandom_range(0, 3))
          0: set_window(7'd0);
          1: set_window(7'd64);
          2: set_window(7'($urandom_range(1, 8)));
          default: set_window(7'($urandom_range(0, 127)));
        endcase
      end
      // burst then gap; some bursts back to back
      for (int b = $urandom_range(1, 12); b > 0 && n < N_RANDOM; b--) begin
        send(rand_row($urandom_range(0, 3) == 0 ? 0 : 1));
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
